FILE: rtl/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types and constants of the rook polynomial counter: field widths,
// controller states and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rpc_pkg;

  // Width of one row mask and of the column scan.
  localparam int unsigned MaskBits = 8;
  // Highest power of the polynomial and the width of the power field.
  localparam int unsigned MaxPower = 8;
  localparam int unsigned PowW     = 4;
  // Coefficient width and its saturation value.
  localparam int unsigned CoefW    = 20;
  localparam logic [CoefW-1:0] CoefMax = {CoefW{1'b1}};
  // One stack entry holds the next option of a row, up to MaskBits + 1.
  localparam int unsigned ChoiceW  = 4;
  // Output data width: power in the low bits, coefficient above.
  localparam int unsigned OutDataW = 24;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SEARCH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;   // store the accepted row
    logic start;  // accepted row was the last one: clear the search state
    logic step;   // run one search step
    logic emit;   // move the next term into the output register
  } cmd_t;

  typedef struct packed {
    logic search_fin; // the current step ends the search
    logic emit_last;  // the next term is the final one
    logic out_free;   // the output register can take a term this cycle
  } status_t;

endpackage

FILE: rtl/rpc_ctrl.sv
// ----------------------------------------------------------------------------
// rpc_ctrl
// Controller: loads rows, runs the search until it ends, then hands the
// terms to the output register one at a time.
// ----------------------------------------------------------------------------
module rpc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  rpc_pkg::status_t status_i,
  output rpc_pkg::cmd_t    cmd_o
);

  rpc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpc_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      rpc_pkg::ST_LOAD: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
        cmd_o.start = in_valid_i & in_last_i;
        if (in_valid_i && in_last_i) begin
          state_d = rpc_pkg::ST_SEARCH;
        end
      end
      rpc_pkg::ST_SEARCH: begin
        cmd_o.step = 1'b1;
        if (status_i.search_fin) begin
          state_d = rpc_pkg::ST_EMIT;
        end
      end
      rpc_pkg::ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
        if (status_i.out_free && status_i.emit_last) begin
          state_d = rpc_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = rpc_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

FILE: rtl/rpc_datapath.sv
// ----------------------------------------------------------------------------
// rpc_datapath
// Row store, backtracking stack, column and rook bookkeeping, coefficient
// table and the output register.
// ----------------------------------------------------------------------------
module rpc_datapath #(
  parameter int unsigned ROWS = 8,
  parameter int unsigned COLS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rpc_pkg::cmd_t                    cmd_i,
  output rpc_pkg::status_t                 status_o,
  input  logic [rpc_pkg::MaskBits-1:0]     row_mask_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [rpc_pkg::PowW-1:0]         out_power_o,
  output logic [rpc_pkg::CoefW-1:0]        out_coef_o,
  output logic                             out_last_o
);

  localparam int unsigned DW = $clog2(ROWS + 1);
  localparam int unsigned IW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CE = (COLS < rpc_pkg::MaskBits) ? COLS : rpc_pkg::MaskBits;
  localparam logic [rpc_pkg::MaskBits-1:0] ColMask = ~({rpc_pkg::MaskBits{1'b1}} << CE);
  localparam int unsigned CW = $clog2(rpc_pkg::MaskBits);

  logic [rpc_pkg::MaskBits-1:0] row_q   [ROWS];
  logic [rpc_pkg::ChoiceW-1:0]  stack_q [ROWS];
  logic [rpc_pkg::CoefW-1:0]    coef_q  [rpc_pkg::MaxPower+1];
  logic [rpc_pkg::CoefW-1:0]    coef_d  [rpc_pkg::MaxPower+1];

  logic [DW-1:0]                rows_q, rows_d;
  logic [DW-1:0]                depth_q, depth_d;
  logic                         ret_q, ret_d;
  logic [rpc_pkg::MaskBits-1:0] used_q, used_d;
  logic [rpc_pkg::PowW-1:0]     placed_q, placed_d;
  logic [rpc_pkg::PowW-1:0]     pow_q, pow_d;

  logic                         out_valid_q, out_valid_d;
  logic [rpc_pkg::PowW-1:0]     out_power_q;
  logic [rpc_pkg::CoefW-1:0]    out_coef_q;
  logic                         out_last_q;

  logic                         stk_we;
  logic [rpc_pkg::ChoiceW-1:0]  stk_wdata;
  logic                         row_we;

  logic [IW-1:0]                idx;
  logic [IW-1:0]                row_widx;
  logic                         leaf;
  logic [rpc_pkg::MaskBits-1:0] cur_row;
  logic [rpc_pkg::ChoiceW-1:0]  cur_opt;
  logic [rpc_pkg::ChoiceW-1:0]  drop_col;
  logic [rpc_pkg::ChoiceW-1:0]  scan_from;
  logic [rpc_pkg::MaskBits-1:0] used_e;
  logic [rpc_pkg::PowW-1:0]     placed_e;
  logic [rpc_pkg::MaskBits-1:0] cand;
  logic                         found;
  logic [CW-1:0]                pick;
  logic [rpc_pkg::PowW-1:0]     leaf_pow;
  logic                         fin;

  assign idx      = depth_q[IW-1:0];
  assign row_widx = rows_q[IW-1:0];
  assign leaf     = (depth_q >= rows_q);
  assign cur_row  = row_q[idx];
  assign cur_opt  = stack_q[idx];
  assign row_we   = cmd_i.load && (rows_q < DW'(ROWS));

  // On return to a row, its previous choice is undone before scanning on.
  assign drop_col  = cur_opt - rpc_pkg::ChoiceW'(2);
  assign scan_from = cur_opt - rpc_pkg::ChoiceW'(1);

  always_comb begin
    used_e   = used_q;
    placed_e = placed_q;
    if (cur_opt >= rpc_pkg::ChoiceW'(2)) begin
      used_e   = used_q & ~(rpc_pkg::MaskBits'(1) << drop_col);
      placed_e = placed_q - rpc_pkg::PowW'(1);
    end
  end

  assign cand  = cur_row & ~used_e & ColMask & ({rpc_pkg::MaskBits{1'b1}} << scan_from);
  assign found = |cand;

  // Lowest free column at or above the resume point.
  always_comb begin
    pick = '0;
    for (int i = rpc_pkg::MaskBits - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick = CW'(i);
      end
    end
  end

  assign leaf_pow = (placed_q > rpc_pkg::PowW'(rpc_pkg::MaxPower)) ?
                    rpc_pkg::PowW'(rpc_pkg::MaxPower) : placed_q;

  always_comb begin
    rows_d      = rows_q;
    depth_d     = depth_q;
    ret_d       = ret_q;
    used_d      = used_q;
    placed_d    = placed_q;
    pow_d       = pow_q;
    coef_d      = coef_q;
    stk_we      = 1'b0;
    stk_wdata   = '0;
    fin         = 1'b0;
    out_valid_d = out_valid_q;

    if (row_we) begin
      rows_d = rows_q + DW'(1);
    end

    if (cmd_i.start) begin
      depth_d  = '0;
      ret_d    = 1'b0;
      used_d   = '0;
      placed_d = '0;
      pow_d    = '0;
      for (int i = 0; i <= rpc_pkg::MaxPower; i++) begin
        coef_d[i] = '0;
      end
    end

    if (cmd_i.step) begin
      if (leaf) begin
        if (coef_q[leaf_pow] != rpc_pkg::CoefMax) begin
          coef_d[leaf_pow] = coef_q[leaf_pow] + rpc_pkg::CoefW'(1);
        end
        if (depth_q == '0) begin
          fin = 1'b1;
        end else begin
          depth_d = depth_q - DW'(1);
          ret_d   = 1'b1;
        end
      end else if (!ret_q) begin
        // Fresh row: the first option leaves it empty.
        stk_we    = 1'b1;
        stk_wdata = rpc_pkg::ChoiceW'(1);
        depth_d   = depth_q + DW'(1);
      end else begin
        used_d   = used_e;
        placed_d = placed_e;
        if (found) begin
          used_d    = used_e | (rpc_pkg::MaskBits'(1) << pick);
          placed_d  = placed_e + rpc_pkg::PowW'(1);
          stk_we    = 1'b1;
          stk_wdata = rpc_pkg::ChoiceW'(pick) + rpc_pkg::ChoiceW'(2);
          depth_d   = depth_q + DW'(1);
          ret_d     = 1'b0;
        end else if (depth_q == '0) begin
          fin = 1'b1;
        end else begin
          depth_d = depth_q - DW'(1);
        end
      end
      if (fin) begin
        rows_d   = '0;
        used_d   = '0;
        placed_d = '0;
        depth_d  = '0;
        ret_d    = 1'b0;
      end
    end

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      pow_d       = pow_q + rpc_pkg::PowW'(1);
      for (int i = 0; i < rpc_pkg::MaxPower; i++) begin
        coef_d[i] = coef_q[i+1];
      end
      coef_d[rpc_pkg::MaxPower] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= '0;
      depth_q     <= '0;
      ret_q       <= 1'b0;
      used_q      <= '0;
      placed_q    <= '0;
      pow_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i <= rpc_pkg::MaxPower; i++) begin
        coef_q[i] <= '0;
      end
    end else begin
      rows_q      <= rows_d;
      depth_q     <= depth_d;
      ret_q       <= ret_d;
      used_q      <= used_d;
      placed_q    <= placed_d;
      pow_q       <= pow_d;
      out_valid_q <= out_valid_d;
      coef_q      <= coef_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_q[row_widx] <= row_mask_i;
    end
    if (stk_we) begin
      stack_q[idx] <= stk_wdata;
    end
    if (cmd_i.emit) begin
      out_power_q <= pow_q;
      out_coef_q  <= coef_q[0];
      out_last_q  <= status_o.emit_last;
    end
  end

  assign status_o.search_fin = fin;
  assign status_o.emit_last  = (coef_q[1] == '0) ||
                               (pow_q == rpc_pkg::PowW'(rpc_pkg::MaxPower));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_power_o = out_power_q;
  assign out_coef_o  = out_coef_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: rtl/rook_polynomial_counter_core.sv
// ----------------------------------------------------------------------------
// rook_polynomial_counter_core
// Loads a board row by row, counts non-attacking rook placements with a
// backtracking search and streams the rook polynomial coefficients.
//
//   Channel  Dir  Signals                  Item
//   s_axis   in   tdata[7:0], tlast        one board row, tlast on last row
//   m_axis   out  tdata[23:0], tlast       one polynomial term, tlast on last
//
// Rows are taken at one per cycle. After the last row the search runs one
// step per cycle (advance into a row, count a full placement, or back up)
// until every node of the search tree has been visited. Terms then leave
// at one per cycle while m_axis_tready is high. s_axis_tready is low
// during search and emission and rises once the final term is registered.
// Reset is asynchronous and active low; the row and stack stores need none.
// ----------------------------------------------------------------------------
module rook_polynomial_counter_core #(
  parameter int unsigned ROWS = 8,
  parameter int unsigned COLS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] row_mask
  input  logic                         s_axis_tlast,   // last_row
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [rpc_pkg::OutDataW-1:0] m_axis_tdata,   // [3:0] power, [23:4] coefficient
  output logic                         m_axis_tlast    // last_term
);

  rpc_pkg::cmd_t             cmd;
  rpc_pkg::status_t          status;
  logic [rpc_pkg::PowW-1:0]  power;
  logic [rpc_pkg::CoefW-1:0] coefficient;

  rpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rpc_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .row_mask_i  (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_power_o (power),
    .out_coef_o  (coefficient),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {coefficient, power};

endmodule

FILE: tb/rook_polynomial_counter_core_test.sv
// ----------------------------------------------------------------------------
// rook_polynomial_counter_core_test
// Streams boards into the rook polynomial counter, row by row, and checks
// every emitted term against coefficients that the bench counts on its own.
// Directed boards come first. Random boards with bounded search effort
// follow under changing idle patterns, one long output stall and pauses
// that let the block drain completely.
// ----------------------------------------------------------------------------
module rook_polynomial_counter_core_test;

  localparam int unsigned BoardRows  = 8;
  localparam int unsigned NodeBudget = 4000;
  localparam int unsigned HoldCycles = 500;

  typedef logic [7:0] rowset_t [16];
  typedef longint unsigned tally_t [rpc_pkg::MaxPower+1];

  typedef struct {
    logic [7:0]  mask;
    logic        last;
    logic        drain;
    int unsigned phase;
  } row_item_t;

  typedef struct packed {
    logic [rpc_pkg::PowW-1:0]  power;
    logic [rpc_pkg::CoefW-1:0] coef;
    logic                      last;
  } term_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata = 8'h00;
  logic                         s_axis_tlast = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [rpc_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         m_axis_tlast;

  row_item_t   row_feed [$];
  term_t       pending_terms [$];
  int unsigned error_count = 0;
  int unsigned rows_seen = 0;
  int unsigned total_rows = 0;
  longint unsigned cycle_count = 0;
  longint unsigned cycle_limit = 64'd1_000_000;
  int unsigned idle_phase = 0;
  int unsigned tx_idle_pct [3] = '{37, 79, 0};
  int unsigned rx_idle_pct [3] = '{79, 37, 0};

  rook_polynomial_counter_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Counts placements per number of rooks by sweeping the rows with a table
  // indexed by the set of used columns. Rows past the store are ignored.
  // The node count sums the partial placements over every prefix of rows,
  // which is what the backtracking search has to visit.
  function automatic void count_rook_placements(input rowset_t rows, input int unsigned len,
                                                output tally_t tally,
                                                output longint unsigned nodes);
    longint unsigned ways [256];
    longint unsigned next_ways [256];
    int unsigned n;
    n = (len < BoardRows) ? len : BoardRows;
    foreach (ways[m]) ways[m] = 0;
    foreach (tally[k]) tally[k] = 0;
    ways[0] = 1;
    nodes = 1;
    for (int r = 0; r < n; r++) begin
      next_ways = ways;
      for (int m = 0; m < 256; m++) begin
        if (ways[m] != 0) begin
          for (int c = 0; c < 8; c++) begin
            if (rows[r][c] && !((m >> c) & 1)) begin
              next_ways[m | (1 << c)] += ways[m];
            end
          end
        end
      end
      ways = next_ways;
      foreach (ways[m]) nodes += ways[m];
    end
    foreach (ways[m]) tally[$countones(m)] += ways[m];
  endfunction

  task automatic queue_board(input rowset_t rows, input int unsigned len,
                             input int unsigned phase, input logic drain);
    for (int i = 0; i < len; i++) begin
      row_feed.insert(row_feed.size(),
                      row_item_t'{mask: rows[i], last: (i == len - 1),
                                  drain: (drain && i == 0), phase: phase});
    end
  endtask

  task automatic report_mismatch(input string field, input longint unsigned want,
                                 input longint unsigned got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    error_count++;
  endtask

  // Sender: one pending row at a time, valid held until the row is taken.
  always @(posedge clk_i) begin
    logic      took;
    row_item_t cur_row;
    logic      holding;
    if (rst_ni) begin
      took = s_axis_tvalid && s_axis_tready;
      if (took) holding = 1'b0;
      // A row marked for draining waits until the previous board has left.
      if (!holding && row_feed.size() != 0 &&
          !(row_feed[0].drain && (took || pending_terms.size() != 0))) begin
        cur_row = row_feed.pop_front();
        holding = 1'b1;
        idle_phase <= cur_row.phase;
      end
      if (!holding) begin
        s_axis_tvalid <= 1'b0;
      end else if (!(s_axis_tvalid && !s_axis_tready)) begin
        s_axis_tvalid <= ($urandom_range(0, 99) >= tx_idle_pct[cur_row.phase]);
        s_axis_tdata  <= cur_row.mask;
        s_axis_tlast  <= cur_row.last;
      end
    end else begin
      holding = 1'b0;
    end
  end

  // Receiver and checker: predicts terms from accepted rows and compares
  // every accepted term with the oldest prediction.
  always @(posedge clk_i) begin
    rowset_t         board_rows;
    int unsigned     board_len;
    int unsigned     hold_left;
    logic            hold_done;
    tally_t          tally;
    longint unsigned nodes;
    int unsigned     n_terms;
    term_t           want;
    if (!rst_ni) begin
      board_len = 0;
      hold_left = 0;
      hold_done = 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_terms.size() == 0) begin
          $display("%0t: unexpected term, expected none, actual power %0d coefficient %0d",
                   $time, m_axis_tdata[rpc_pkg::PowW-1:0],
                   m_axis_tdata[rpc_pkg::PowW +: rpc_pkg::CoefW]);
          error_count++;
        end else begin
          want = pending_terms.pop_front();
          if (m_axis_tdata[rpc_pkg::PowW-1:0] != want.power) begin
            report_mismatch("power", want.power, m_axis_tdata[rpc_pkg::PowW-1:0]);
          end
          if (m_axis_tdata[rpc_pkg::PowW +: rpc_pkg::CoefW] != want.coef) begin
            report_mismatch("coefficient", want.coef,
                            m_axis_tdata[rpc_pkg::PowW +: rpc_pkg::CoefW]);
          end
          if (m_axis_tlast != want.last) begin
            report_mismatch("last_term", want.last, m_axis_tlast);
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        rows_seen++;
        if (board_len < BoardRows) begin
          board_rows[board_len] = s_axis_tdata;
          board_len++;
        end
        if (s_axis_tlast) begin
          count_rook_placements(board_rows, board_len, tally, nodes);
          n_terms = 0;
          while (n_terms <= rpc_pkg::MaxPower && tally[n_terms] != 0) n_terms++;
          for (int k = 0; k < n_terms; k++) begin
            want.power = rpc_pkg::PowW'(k);
            want.coef  = (tally[k] > rpc_pkg::CoefMax) ? rpc_pkg::CoefMax :
                         rpc_pkg::CoefW'(tally[k]);
            want.last  = (k == n_terms - 1);
            pending_terms.insert(pending_terms.size(), want);
          end
          board_len = 0;
        end
      end

      // One long stall late in the run lets the block back up onto its input.
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && rows_seen >= 250) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct[idle_phase]);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("rook_polynomial_counter_core_test: done, errors");
      $finish;
    end
  end

  initial begin
    rowset_t         board;
    tally_t          tally;
    longint unsigned nodes;
    longint unsigned nodes_sum;
    int unsigned     rand_rows;
    int unsigned     len;
    int unsigned     phase;
    int unsigned     prev_phase;
    int unsigned     boards;
    logic            mid_drained;
    logic            drain;
    int unsigned     pick;

    foreach (board[i]) board[i] = 8'h00;
    nodes_sum = 0;
    boards = 0;

    // Empty row alone: only the power 0 term.
    board[0] = 8'h00;
    queue_board(board, 1, 0, 1'b0);
    // Full row alone.
    board[0] = 8'hFF;
    queue_board(board, 1, 0, 1'b0);
    // One distinct column per row: all nine terms, every mask bit set once.
    for (int i = 0; i < 8; i++) board[i] = 8'(1 << i);
    queue_board(board, 8, 0, 1'b0);
    // Two rows on disjoint columns.
    board[0] = 8'hAA;
    board[1] = 8'h55;
    queue_board(board, 2, 0, 1'b0);
    // Board longer than the store: the extra rows must be dropped, and the
    // last flag on a dropped row still starts the count.
    for (int i = 0; i < 8; i++) board[i] = 8'h81;
    board[8]  = 8'hFF;
    board[9]  = 8'h7E;
    board[10] = 8'hFF;
    queue_board(board, 11, 0, 1'b0);
    boards = 5;
    nodes_sum = 2000;

    rand_rows = 0;
    prev_phase = 0;
    mid_drained = 1'b0;
    while (rand_rows < 287) begin
      phase = (rand_rows < 96) ? 0 : (rand_rows < 192) ? 1 : 2;
      drain = (phase != prev_phase);
      if (!mid_drained && rand_rows >= 48) begin
        drain = 1'b1;
        mid_drained = 1'b1;
      end
      prev_phase = phase;
      pick = $urandom_range(0, 99);
      if (pick < 70) len = $urandom_range(1, 4);
      else if (pick < 92) len = $urandom_range(5, 8);
      else len = $urandom_range(9, 10);
      // Dense boards explode the search, so redraw until the effort is small.
      do begin
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(0, 9);
          case (pick)
            0: board[i] = 8'hFF;
            1: board[i] = 8'h00;
            2, 3, 4: board[i] = 8'(1 << $urandom_range(0, 7));
            5, 6, 7: board[i] = 8'($urandom & $urandom);
            default: board[i] = 8'($urandom);
          endcase
        end
        count_rook_placements(board, len, tally, nodes);
      end while (nodes > NodeBudget);
      queue_board(board, len, phase, drain);
      nodes_sum += nodes;
      boards++;
      rand_rows += len;
    end

    total_rows = row_feed.size();
    cycle_limit = 200_000 + 12 * nodes_sum + 800 * boards + 80 * total_rows + HoldCycles;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rows_seen < total_rows || pending_terms.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    if (error_count == 0) begin
      $display("rook_polynomial_counter_core_test: done, clean");
    end else begin
      $display("rook_polynomial_counter_core_test: done, errors");
    end
    $finish;
  end

endmodule
